// ----- rtl/rtcr_pkg.sv -----
// package for the ring answer and tone code relay
// types, codes and helpers shared by rtcr_ring, rtcr_code and the top level
// no dependencies

package rtcr_pkg;

  // default build parameters
  localparam int DEF_CODE_LENGTH = 5;
  localparam int DEF_NUM_CODES   = 4;

  // fixed widths of the item fields
  localparam int SYM_W     = 4;
  localparam int MAX_CODES = 4;
  localparam int STATUS_W  = 2;
  localparam int OUTCOME_W = 2;
  localparam int MATCH_W   = 2;
  localparam int HELD_W    = 3;
  localparam int LIMIT_W   = 4;
  localparam int CFG_IDX_W = 3;

  // event kinds
  localparam logic OP_RING = 1'b0;
  localparam logic OP_TONE = 1'b1;

  // call status codes as seen on the result
  localparam logic [STATUS_W-1:0] STATUS_IDLE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RINGING = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ONLINE  = 2'd2;

  // code verdicts
  localparam logic [OUTCOME_W-1:0] OUTCOME_NONE    = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_APPLIED = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_INVALID = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RINGS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_3 = 3'd4;

  // reset values of the configuration registers
  localparam logic [LIMIT_W-1:0] RINGS_RESET = 4'd4;
  localparam logic [31:0] CODE_RESET [MAX_CODES] = '{
    32'h000C_111B, 32'h000C_222B, 32'h000C_333B, 32'h000C_444B
  };

  // tone symbols
  localparam logic [SYM_W-1:0] SYM_BLANK   = 4'd0;
  localparam logic [SYM_W-1:0] SYM_DIGIT_1 = 4'd1;
  localparam logic [SYM_W-1:0] SYM_HASH    = 4'd12;

  // line status, one-hot
  typedef enum logic [2:0] {
    LINE_IDLE    = 3'b001,
    LINE_RINGING = 3'b010,
    LINE_ONLINE  = 3'b100
  } line_state_t;

  // result fields produced by the code entry unit
  typedef struct packed {
    logic [MAX_CODES-1:0] relays;
    logic [OUTCOME_W-1:0] outcome;
    logic [MATCH_W-1:0]   matched;
    logic [HELD_W-1:0]    held;
  } code_res_t;

  // nibbles above hash fold to digit 1, zero stays blank
  function automatic logic [SYM_W-1:0] norm_symbol(input logic [SYM_W-1:0] t);
    logic [SYM_W-1:0] s;
    s = (t > SYM_HASH) ? SYM_DIGIT_1 : t;
    return s;
  endfunction

  function automatic logic [STATUS_W-1:0] status_code(input line_state_t st);
    logic [STATUS_W-1:0] c;
    case (st)
      LINE_RINGING: c = STATUS_RINGING;
      LINE_ONLINE:  c = STATUS_ONLINE;
      default:      c = STATUS_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/ring_answer_and_tone_code_relay.sv -----
// top level of the ring answer and tone code relay
// depends on rtcr_pkg, rtcr_ring and rtcr_code

// Each item is either a ring edge or a decoded tone nibble, and each gives
// exactly one result carrying the call status, the four relay states, the
// verdict of a completed code entry, the toggled relay index and the number
// of entry symbols held. The block takes one item per clock while in_stall
// is low and passes it through the input register and then the update
// logic that writes the result register. In that update the ring counter,
// the entry store and the compare against all code words happen together.
// A full result register held by out_stall pushes back on in_stall in the
// same cycle only when the input register is also full. Configuration
// writes are registered and must be made with no item in flight.

module ring_answer_and_tone_code_relay #(
  parameter int CODE_LENGTH = rtcr_pkg::DEF_CODE_LENGTH,
  parameter int NUM_CODES   = rtcr_pkg::DEF_NUM_CODES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic [rtcr_pkg::SYM_W-1:0]        in_tone,
  // result items
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rtcr_pkg::STATUS_W-1:0]     out_call_status,
  output logic [rtcr_pkg::MAX_CODES-1:0]    out_relay_bits,
  output logic [rtcr_pkg::OUTCOME_W-1:0]    out_code_outcome,
  output logic [rtcr_pkg::MATCH_W-1:0]      out_matched_index,
  output logic [rtcr_pkg::HELD_W-1:0]       out_symbols_held,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [rtcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtcr_pkg::SYM_W*CODE_LENGTH-1:0] cfg_wdata
);

  localparam int CODE_BITS = rtcr_pkg::SYM_W * CODE_LENGTH;

  // configuration registers
  logic [rtcr_pkg::LIMIT_W-1:0] rings_r;
  logic [CODE_BITS-1:0]         code_r [rtcr_pkg::MAX_CODES];

  // input register
  logic                         in_valid_r;
  logic                         in_op_r;
  logic [rtcr_pkg::SYM_W-1:0]   in_tone_r;

  // result register
  logic                          out_valid_r;
  logic [rtcr_pkg::STATUS_W-1:0] status_r;
  rtcr_pkg::code_res_t           res_r;

  logic                          adv;
  logic                          fire;
  logic [rtcr_pkg::STATUS_W-1:0] status_nxt;
  rtcr_pkg::code_res_t           code_nxt;

  // the result register moves when it is empty or being taken
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !adv;
  assign fire     = in_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rings_r <= rtcr_pkg::RINGS_RESET;
      for (int i = 0; i < rtcr_pkg::MAX_CODES; i++) begin
        code_r[i] <= CODE_BITS'(rtcr_pkg::CODE_RESET[i]);
      end
    end else if (cfg_we) begin
      case (cfg_index)
        rtcr_pkg::REG_RINGS:  rings_r   <= cfg_wdata[rtcr_pkg::LIMIT_W-1:0];
        rtcr_pkg::REG_CODE_0: code_r[0] <= cfg_wdata;
        rtcr_pkg::REG_CODE_1: code_r[1] <= cfg_wdata;
        rtcr_pkg::REG_CODE_2: code_r[2] <= cfg_wdata;
        rtcr_pkg::REG_CODE_3: code_r[3] <= cfg_wdata;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // input register, loads whenever it is not holding a stalled item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_op_r   <= in_op;
      in_tone_r <= in_tone;
    end
  end

  rtcr_ring u_ring (
    .clk             (clk),
    .rst_n           (rst_n),
    .ring_fire       (fire && in_op_r == rtcr_pkg::OP_RING),
    .limit           (rings_r),
    .status_nxt_code (status_nxt)
  );

  rtcr_code #(
    .CODE_LENGTH (CODE_LENGTH),
    .NUM_CODES   (NUM_CODES)
  ) u_code (
    .clk        (clk),
    .rst_n      (rst_n),
    .tone_fire  (fire && in_op_r == rtcr_pkg::OP_TONE),
    .tone       (in_tone_r),
    .code_words (code_r),
    .res_nxt    (code_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= status_nxt;
      res_r    <= code_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_call_status   = status_r;
  assign out_relay_bits    = res_r.relays;
  assign out_code_outcome  = res_r.outcome;
  assign out_matched_index = res_r.matched;
  assign out_symbols_held  = res_r.held;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r)
    else $error("input stalled with nothing blocking it");

  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r) else $error("processed item gave no result");

  a_ring_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_op_r == rtcr_pkg::OP_RING |=>
      res_r.outcome == rtcr_pkg::OUTCOME_NONE && res_r.matched == '0)
    else $error("ring item carried a code verdict");

endmodule

// ----- rtl/rtcr_ring.sv -----
// ring counter and line status for the ring answer and tone code relay
// depends on rtcr_pkg

module rtcr_ring (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ring_fire,
  input  logic [rtcr_pkg::LIMIT_W-1:0]  limit,
  output logic [rtcr_pkg::STATUS_W-1:0] status_nxt_code
);

  logic [rtcr_pkg::LIMIT_W-1:0] tally_r, tally_nxt;
  rtcr_pkg::line_state_t        line_r, line_nxt;

  always_comb begin
    tally_nxt = tally_r;
    line_nxt  = line_r;
    if (ring_fire) begin
      if (tally_r == limit) begin
        // answer the call
        line_nxt  = rtcr_pkg::LINE_ONLINE;
        tally_nxt = '0;
      end else if (tally_r < limit && line_r != rtcr_pkg::LINE_ONLINE) begin
        tally_nxt = tally_r + 1'b1;
        line_nxt  = rtcr_pkg::LINE_RINGING;
      end
    end
  end

  assign status_nxt_code = rtcr_pkg::status_code(line_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r <= '0;
      line_r  <= rtcr_pkg::LINE_IDLE;
    end else begin
      tally_r <= tally_nxt;
      line_r  <= line_nxt;
    end
  end

  a_line_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(line_r)) else $error("line status lost its one-hot code");

  a_answer_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ring_fire && tally_r == limit |=> tally_r == '0 && line_r == rtcr_pkg::LINE_ONLINE)
    else $error("answering ring did not go online");

  a_online_holds: assert property (@(posedge clk) disable iff (!rst_n)
    line_r == rtcr_pkg::LINE_ONLINE |=> line_r == rtcr_pkg::LINE_ONLINE)
    else $error("line left online");

endmodule

// ----- rtl/rtcr_code.sv -----
// tone entry collection, code compare and relay toggling
// depends on rtcr_pkg

module rtcr_code #(
  parameter int CODE_LENGTH = rtcr_pkg::DEF_CODE_LENGTH,
  parameter int NUM_CODES   = rtcr_pkg::DEF_NUM_CODES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            tone_fire,
  input  logic [rtcr_pkg::SYM_W-1:0]      tone,
  input  logic [rtcr_pkg::SYM_W*CODE_LENGTH-1:0] code_words [rtcr_pkg::MAX_CODES],
  output rtcr_pkg::code_res_t             res_nxt
);

  localparam int CODE_BITS = rtcr_pkg::SYM_W * CODE_LENGTH;
  localparam int POS_W     = $clog2(CODE_LENGTH);
  localparam int STORED    = CODE_LENGTH - 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(CODE_LENGTH - 1);

  logic [POS_W-1:0]                 pos_r, pos_nxt;
  logic [rtcr_pkg::SYM_W-1:0]       entry_r [STORED];
  logic [rtcr_pkg::MAX_CODES-1:0]   relay_r, relay_nxt;
  logic [rtcr_pkg::SYM_W-1:0]       sym;
  logic [rtcr_pkg::MAX_CODES-1:0]   hit;
  logic [rtcr_pkg::MATCH_W-1:0]     first_idx;
  logic [rtcr_pkg::OUTCOME_W-1:0]   outcome;
  logic [rtcr_pkg::MATCH_W-1:0]     matched;
  logic                             store;
  logic                             complete;

  assign sym      = rtcr_pkg::norm_symbol(tone);
  assign store    = tone_fire && pos_r < LAST_POS;
  assign complete = tone_fire && pos_r == LAST_POS;

  // each code against the stored symbols plus the incoming last one
  always_comb begin
    logic h;
    hit = '0;
    for (int i = 0; i < rtcr_pkg::MAX_CODES; i++) begin
      h = (i < NUM_CODES);
      for (int k = 0; k < STORED; k++) begin
        if (entry_r[k] == rtcr_pkg::SYM_BLANK ||
            entry_r[k] != code_words[i][rtcr_pkg::SYM_W*k +: rtcr_pkg::SYM_W]) begin
          h = 1'b0;
        end
      end
      if (sym == rtcr_pkg::SYM_BLANK ||
          sym != code_words[i][CODE_BITS-1 -: rtcr_pkg::SYM_W]) begin
        h = 1'b0;
      end
      hit[i] = h;
    end
  end

  // lowest matching code wins
  always_comb begin
    first_idx = '0;
    for (int i = rtcr_pkg::MAX_CODES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        first_idx = rtcr_pkg::MATCH_W'(i);
      end
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    relay_nxt = relay_r;
    outcome   = rtcr_pkg::OUTCOME_NONE;
    matched   = '0;
    if (store) begin
      pos_nxt = pos_r + 1'b1;
    end else if (complete) begin
      pos_nxt = '0;
      if (|hit) begin
        outcome   = rtcr_pkg::OUTCOME_APPLIED;
        matched   = first_idx;
        relay_nxt = relay_r ^ (rtcr_pkg::MAX_CODES'(1) << first_idx);
      end else begin
        outcome = rtcr_pkg::OUTCOME_INVALID;
      end
    end else if (tone_fire) begin
      // out-of-range position, cleared quietly
      pos_nxt = '0;
    end
  end

  assign res_nxt.relays  = relay_nxt;
  assign res_nxt.outcome = outcome;
  assign res_nxt.matched = matched;
  assign res_nxt.held    = rtcr_pkg::HELD_W'(pos_nxt);

  always_ff @(posedge clk) begin
    for (int k = 0; k < STORED; k++) begin
      if (store && pos_r == POS_W'(k)) begin
        entry_r[k] <= sym;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      relay_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      relay_r <= relay_nxt;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS) else $error("entry position out of range");

  a_one_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    complete && (|hit) |=> $countones(relay_r ^ $past(relay_r)) == 1)
    else $error("applied code did not toggle exactly one relay");

  a_relays_still: assert property (@(posedge clk) disable iff (!rst_n)
    !complete |=> relay_r == $past(relay_r))
    else $error("relays changed without a completed entry");

endmodule
